>>> src/tep_pkg.sv
// Shared types and constants for the tilt estimate / PID drive core.
// Used by the controller, the datapath, the multiplier and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tep_pkg;

  // multiplier geometry: signed A x signed B (n bits of B), wide accumulator
  localparam int MUL_AW = 48;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = 80;
  localparam int MUL_NW = 5;

  // multiplier operand lengths in bits, sign bit included
  localparam logic [MUL_NW-1:0] N_DT   = 5'd25;
  localparam logic [MUL_NW-1:0] N_GAIN = 5'd17;
  localparam logic [MUL_NW-1:0] N_WC   = 5'd18;
  localparam logic [MUL_NW-1:0] N_RAD  = 5'd28;

  localparam logic [MUL_BW-1:0] DEG_TO_RAD_Q32 = 32'd74961321;

  localparam int SQRT_ITERS = 32;
  localparam int DIV_ITERS  = 56;
  localparam int ATAN_DEPTH = 24;
  localparam int CNT_W      = 6;

  // CORDIC angle table, degrees Q16.16
  localparam logic signed [31:0] ATAN_DEG [ATAN_DEPTH] = '{
    32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945, 32'sd234379, 32'sd117304,
    32'sd58666, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
    32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57, 32'sd29,
    32'sd14, 32'sd7, 32'sd4, 32'sd2, 32'sd1, 32'sd0
  };

  typedef enum logic [2:0] {
    REG_SETPOINT = 3'd0,
    REG_GAIN_P   = 3'd1,
    REG_GAIN_I   = 3'd2,
    REG_GAIN_D   = 3'd3,
    REG_WEIGHT   = 3'd4,
    REG_TSTEP    = 3'd5,
    REG_LIMIT    = 3'd6,
    REG_NONE     = 3'd7
  } reg_idx_t;

  localparam logic [23:0] RST_SETPOINT = 24'd0;
  localparam logic [15:0] RST_GAIN_P   = 16'd51200;
  localparam logic [15:0] RST_GAIN_I   = 16'd0;
  localparam logic [15:0] RST_GAIN_D   = 16'd0;
  localparam logic [15:0] RST_WEIGHT   = 16'd52429;
  localparam logic [23:0] RST_TSTEP    = 24'd50332;
  localparam logic [7:0]  RST_LIMIT    = 8'd255;

  typedef struct packed {
    logic [23:0] setpoint_angle;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] filter_weight;
    logic [23:0] time_step;
    logic [7:0]  output_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_IDLE    = 4'd0,
    OP_LOAD    = 4'd1,
    OP_SQ_X    = 4'd2,
    OP_SQ_Y    = 4'd3,
    OP_SQRT    = 4'd4,
    OP_CORDIC  = 4'd5,
    OP_GYRO    = 4'd6,
    OP_BLEND_T = 4'd7,
    OP_BLEND_P = 4'd8,
    OP_ERR     = 4'd9,
    OP_DIV     = 4'd10,
    OP_ISUM    = 4'd11,
    OP_PID_P   = 4'd12,
    OP_PID_I   = 4'd13,
    OP_PID_D   = 4'd14,
    OP_OUT     = 4'd15
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             start;
    logic             run;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic dt_zero;
  } status_t;

endpackage

`default_nettype wire

>>> src/tep_mul.sv
// Shift-add signed multiplier, one bit of B per cycle, optional accumulate.
// Depends on tep_pkg for the operand and accumulator widths.
`timescale 1ns / 1ps
`default_nettype none

module tep_mul
  import tep_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic                     clear,
  input  wire logic signed [MUL_AW-1:0] a,
  input  wire logic signed [MUL_BW-1:0] b,
  input  wire logic [MUL_NW-1:0]        n,
  output logic signed [MUL_PW-1:0]      acc,
  output logic                          done
);

  logic                     busy;
  logic [MUL_NW-1:0]        cnt;
  logic [MUL_NW-1:0]        len;
  logic signed [MUL_PW-1:0] as;
  logic signed [MUL_BW-1:0] bs;
  logic                     last;
  logic signed [MUL_PW-1:0] addend;

  assign last = (cnt == len - 1'b1);

  // top bit of B carries negative weight
  always_comb begin
    if (bs[0]) begin
      addend = last ? -as : as;
    end else begin
      addend = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      len <= n;
      as  <= MUL_PW'(a);
      bs  <= b;
      if (clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      acc <= acc + addend;
      as  <= as <<< 1;
      bs  <= bs >>> 1;
      cnt <= cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> src/tep_ctrl.sv
// Sequencer for the tilt / PID datapath: one step per state, handshakes.
// Depends on tep_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module tep_ctrl
  import tep_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    sample_valid,
  output logic         sample_stall,
  output logic         result_valid,
  input  wire logic    result_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam int CSTEPS = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;

  typedef enum logic [14:0] {
    ST_IDLE    = 15'h0001,
    ST_SQ_X    = 15'h0002,
    ST_SQ_Y    = 15'h0004,
    ST_SQRT    = 15'h0008,
    ST_CORDIC  = 15'h0010,
    ST_GYRO    = 15'h0020,
    ST_BLEND_T = 15'h0040,
    ST_BLEND_P = 15'h0080,
    ST_ERR     = 15'h0100,
    ST_DIV     = 15'h0200,
    ST_ISUM    = 15'h0400,
    ST_PID_P   = 15'h0800,
    ST_PID_I   = 15'h1000,
    ST_PID_D   = 15'h2000,
    ST_FINISH  = 15'h4000
  } state_t;

  state_t           state, state_next, succ;
  logic             busy, busy_next;
  logic [CNT_W-1:0] cnt, cnt_next, last_idx;
  logic             result_valid_next;
  logic             is_iter;
  op_t              op;

  always_comb begin
    succ     = ST_IDLE;
    op       = OP_IDLE;
    is_iter  = 1'b0;
    last_idx = '0;
    unique case (state)
      ST_IDLE:    begin succ = ST_SQ_X;    op = OP_LOAD;    end
      ST_SQ_X:    begin succ = ST_SQ_Y;    op = OP_SQ_X;    end
      ST_SQ_Y:    begin succ = ST_SQRT;    op = OP_SQ_Y;    end
      ST_SQRT:    begin
        succ = ST_CORDIC; op = OP_SQRT; is_iter = 1'b1;
        last_idx = CNT_W'(SQRT_ITERS - 1);
      end
      ST_CORDIC:  begin
        succ = ST_GYRO; op = OP_CORDIC; is_iter = 1'b1;
        last_idx = CNT_W'(CSTEPS - 1);
      end
      ST_GYRO:    begin succ = ST_BLEND_T; op = OP_GYRO;    end
      ST_BLEND_T: begin succ = ST_BLEND_P; op = OP_BLEND_T; end
      ST_BLEND_P: begin succ = ST_ERR;     op = OP_BLEND_P; end
      ST_ERR:     begin succ = ST_DIV;     op = OP_ERR;     end
      ST_DIV:     begin
        succ = ST_ISUM; op = OP_DIV; is_iter = 1'b1;
        last_idx = CNT_W'(DIV_ITERS - 1);
      end
      ST_ISUM:    begin succ = ST_PID_P;   op = OP_ISUM;    end
      ST_PID_P:   begin succ = ST_PID_I;   op = OP_PID_P;   end
      ST_PID_I:   begin succ = ST_PID_D;   op = OP_PID_I;   end
      ST_PID_D:   begin succ = ST_FINISH;  op = OP_PID_D;   end
      ST_FINISH:  begin succ = ST_IDLE;    op = OP_OUT;     end
      default:    begin succ = ST_IDLE;    op = OP_IDLE;    end
    endcase
  end

  always_comb begin
    state_next        = state;
    busy_next         = busy;
    cnt_next          = cnt;
    result_valid_next = result_valid && result_stall;
    cmd               = '{op: OP_IDLE, start: 1'b0, run: 1'b0, idx: cnt};
    priority if (state == ST_IDLE) begin
      if (sample_valid) begin
        cmd.op     = OP_LOAD;
        cmd.start  = 1'b1;
        state_next = succ;
      end
    end else if (state == ST_FINISH) begin
      // result register frees up the same cycle it is taken
      if (!result_valid || !result_stall) begin
        cmd.op            = OP_OUT;
        cmd.start         = 1'b1;
        result_valid_next = 1'b1;
        state_next        = succ;
      end
    end else if (!busy) begin
      cmd.op    = op;
      cmd.start = 1'b1;
      busy_next = 1'b1;
      cnt_next  = '0;
      if (state == ST_DIV && status.dt_zero) begin
        busy_next  = 1'b0;
        state_next = succ;
      end
    end else if (!is_iter) begin
      cmd.op = op;
      if (status.mul_done) begin
        busy_next  = 1'b0;
        state_next = succ;
      end
    end else begin
      cmd.op  = op;
      cmd.run = 1'b1;
      if (cnt == last_idx) begin
        busy_next  = 1'b0;
        state_next = succ;
      end else begin
        cnt_next = cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      busy         <= 1'b0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      busy         <= busy_next;
      cnt          <= cnt_next;
      result_valid <= result_valid_next;
    end
  end

  assign sample_stall = (state != ST_IDLE);

endmodule

`default_nettype wire

>>> src/tep_datapath.sv
// Datapath: sample averaging, square root, CORDIC atan, blend, PID, divider.
// Depends on tep_pkg and instantiates tep_mul.
`timescale 1ns / 1ps
`default_nettype none

module tep_datapath
  import tep_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cfg_t                           cfg,
  input  wire cmd_t                           cmd,
  output status_t                             status,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_x_first,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_x_second,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_y_first,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_y_second,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_z_first,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_z_second,
  input  wire logic signed [SAMPLE_WIDTH-1:0] rate_y_first,
  input  wire logic signed [SAMPLE_WIDTH-1:0] rate_y_second,
  output logic signed [8:0]                   drive_value,
  output logic [7:0]                          drive_magnitude,
  output logic                                forward,
  output logic signed [31:0]                  tilt_angle
);

  localparam int SW = SAMPLE_WIDTH;

  function automatic logic signed [SW-1:0] avg2(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    logic signed [SW:0] s;
    s = (SW+1)'(a) + (SW+1)'(b);
    s = s + (SW+1)'(s[SW]);
    return s[SW:1];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [MUL_PW-1:0] v);
    if (v > $signed(MUL_PW'(32'h7FFF_FFFF))) begin
      return 32'sh7FFF_FFFF;
    end else if (v < $signed({{(MUL_PW-31){1'b1}}, 31'b0})) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
    if (v > $signed({9'b0, {39{1'b1}}})) begin
      return {1'b0, {39{1'b1}}};
    end else if (v < $signed({9'h1FF, 39'b0})) begin
      return {1'b1, 39'b0};
    end else begin
      return v[39:0];
    end
  endfunction

  // ---- working registers
  logic signed [SW-1:0] ax, ay, az, gy;
  logic [63:0]          sq_n, root, bit_r;
  logic signed [39:0]   cx, cy;
  logic signed [31:0]   cz;
  logic                 zero_in;
  logic signed [47:0]   t;
  logic signed [31:0]   fused, err, prev_err, deriv;
  logic signed [39:0]   esum;
  logic [55:0]          dq;
  logic [23:0]          drem;
  logic                 dneg;

  // ---- multiplier
  logic                     mul_go, mul_clear, mul_done;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic [MUL_NW-1:0]        mul_n;
  logic signed [MUL_PW-1:0] acc;

  logic signed [31:0] pitch;
  logic signed [33:0] ang_diff;
  logic [16:0]        w_comp;

  assign pitch    = zero_in ? 32'sd0 : cz;
  assign ang_diff = 34'($signed(cfg.setpoint_angle)) - 34'(fused);
  assign w_comp   = 17'h1_0000 - {1'b0, cfg.filter_weight};

  always_comb begin
    mul_go    = 1'b0;
    mul_clear = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_n     = '0;
    unique case (cmd.op)
      OP_SQ_X: begin
        mul_go = 1'b1; mul_clear = 1'b1;
        mul_a = MUL_AW'(ax); mul_b = MUL_BW'(ax); mul_n = MUL_NW'(SW);
      end
      OP_SQ_Y: begin
        mul_go = 1'b1;
        mul_a = MUL_AW'(ay); mul_b = MUL_BW'(ay); mul_n = MUL_NW'(SW);
      end
      OP_GYRO: begin
        mul_go = 1'b1; mul_clear = 1'b1;
        mul_a = MUL_AW'(gy); mul_b = {8'b0, cfg.time_step}; mul_n = N_DT;
      end
      OP_BLEND_T: begin
        mul_go = 1'b1; mul_clear = 1'b1;
        mul_a = t; mul_b = {16'b0, cfg.filter_weight}; mul_n = N_GAIN;
      end
      OP_BLEND_P: begin
        mul_go = 1'b1;
        mul_a = MUL_AW'(pitch); mul_b = {15'b0, w_comp}; mul_n = N_WC;
      end
      OP_ERR: begin
        mul_go = 1'b1; mul_clear = 1'b1;
        mul_a = MUL_AW'(ang_diff); mul_b = DEG_TO_RAD_Q32; mul_n = N_RAD;
      end
      OP_ISUM: begin
        mul_go = 1'b1; mul_clear = 1'b1;
        mul_a = MUL_AW'(err); mul_b = {8'b0, cfg.time_step}; mul_n = N_DT;
      end
      OP_PID_P: begin
        mul_go = 1'b1; mul_clear = 1'b1;
        mul_a = MUL_AW'(err); mul_b = {16'b0, cfg.gain_p}; mul_n = N_GAIN;
      end
      OP_PID_I: begin
        mul_go = 1'b1;
        mul_a = MUL_AW'(esum); mul_b = {16'b0, cfg.gain_i}; mul_n = N_GAIN;
      end
      OP_PID_D: begin
        mul_go = 1'b1;
        mul_a = MUL_AW'(deriv); mul_b = {16'b0, cfg.gain_d}; mul_n = N_GAIN;
      end
      default: ;
    endcase
  end

  tep_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go && cmd.start),
    .clear (mul_clear),
    .a     (mul_a),
    .b     (mul_b),
    .n     (mul_n),
    .acc   (acc),
    .done  (mul_done)
  );

  assign status.mul_done = mul_done;
  assign status.dt_zero  = (cfg.time_step == '0);

  // ---- iteration steps
  logic [63:0]        sq_try;
  logic signed [39:0] xsh, ysh;
  logic [4:0]         ci;
  logic [24:0]        d_try;
  logic               d_ge;
  logic signed [32:0] e_diff;
  logic [32:0]        e_mag;
  logic signed [31:0] deriv_q;

  assign sq_try = root + bit_r;
  assign ci     = cmd.idx[4:0];
  assign xsh    = cx >>> ci;
  assign ysh    = cy >>> ci;
  assign d_try  = {drem, dq[55]};
  assign d_ge   = (d_try >= {1'b0, cfg.time_step});
  assign e_diff = 33'(err) - 33'(prev_err);
  assign e_mag  = e_diff[32] ? 33'(-e_diff) : 33'(e_diff);

  always_comb begin
    if (!dneg) begin
      deriv_q = (dq > 56'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dq[31:0]);
    end else begin
      deriv_q = (dq > 56'h8000_0000) ? 32'sh8000_0000 : $signed(-dq[31:0]);
    end
  end

  // ---- drive
  logic signed [MUL_PW-1:0] tot_adj, tot_q, lim_s;
  logic signed [8:0]        drive;

  assign tot_adj = acc + $signed({{(MUL_PW-24){1'b0}}, {24{acc[MUL_PW-1]}}});
  assign tot_q   = tot_adj >>> 24;
  assign lim_s   = $signed({{(MUL_PW-8){1'b0}}, cfg.output_limit});

  always_comb begin
    priority if (tot_q > lim_s) begin
      drive = 9'(lim_s);
    end else if (tot_q < -lim_s) begin
      drive = 9'(-lim_s);
    end else begin
      drive = 9'(tot_q);
    end
  end

  // ---- estimator / PID state
  always_ff @(posedge clk) begin
    if (rst) begin
      fused    <= '0;
      prev_err <= '0;
      esum     <= '0;
    end else if (mul_done && cmd.op == OP_BLEND_P) begin
      fused <= sat32(acc >>> 16);
    end else if (mul_done && cmd.op == OP_ISUM) begin
      esum     <= sat40(48'(esum) + 48'(acc >>> 24));
      prev_err <= err;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        if (cmd.start) begin
          ax <= avg2(accel_x_first, accel_x_second);
          ay <= avg2(accel_y_first, accel_y_second);
          az <= avg2(accel_z_first, accel_z_second);
          gy <= avg2(rate_y_first, rate_y_second);
        end
      end
      OP_SQRT: begin
        if (cmd.start) begin
          sq_n    <= {acc[47:0], 16'b0};
          zero_in <= (acc[47:0] == '0) && (az == '0);
          root    <= '0;
          bit_r   <= 64'h4000_0000_0000_0000;
        end else if (cmd.run) begin
          if (sq_n >= sq_try) begin
            sq_n <= sq_n - sq_try;
            root <= (root >> 1) + bit_r;
          end else begin
            root <= root >> 1;
          end
          bit_r <= bit_r >> 2;
        end
      end
      OP_CORDIC: begin
        if (cmd.start) begin
          cx <= 40'(root);
          cy <= -(40'(az) <<< 8);
          cz <= '0;
        end else if (cmd.run) begin
          if (!cy[39]) begin
            cx <= cx + ysh;
            cy <= cy - xsh;
            cz <= cz + ATAN_DEG[ci];
          end else begin
            cx <= cx - ysh;
            cy <= cy + xsh;
            cz <= cz - ATAN_DEG[ci];
          end
        end
      end
      OP_GYRO: begin
        if (mul_done) begin
          t <= 48'(fused) + 48'(acc >>> 8);
        end
      end
      OP_ERR: begin
        if (mul_done) begin
          err <= 32'(acc >>> 32);
        end
      end
      OP_DIV: begin
        if (cmd.start) begin
          deriv <= '0;
          dneg  <= e_diff[32];
          dq    <= {e_mag[31:0], 24'b0};
          drem  <= '0;
        end else if (cmd.run) begin
          drem <= d_ge ? 24'(d_try - {1'b0, cfg.time_step}) : d_try[23:0];
          dq   <= {dq[54:0], d_ge};
        end
      end
      OP_ISUM: begin
        if (cmd.start && !status.dt_zero) begin
          deriv <= deriv_q;
        end
      end
      OP_OUT: begin
        if (cmd.start) begin
          drive_value     <= drive;
          drive_magnitude <= drive[8] ? 8'(-drive) : drive[7:0];
          forward         <= !drive[8] && (drive != '0);
          tilt_angle      <= fused;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/tilt_estimate_pid_drive_core.sv
// Tilt estimate and PID drive core: one result beat per sample beat.
// The shared multiplier works one bit per cycle; the square root and divider are
// bit-serial, and the divider steps are skipped when time_step is zero. One sample
// is processed at a time; the next sample is taken while a result waits.
// Reset (rst, synchronous): registers to defaults, angle and PID state to zero.
`timescale 1ns / 1ps
`default_nettype none

module tilt_estimate_pid_drive_core
  import tep_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [4:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  wire logic                           sample_valid,
  output logic                                sample_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_x_first,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_x_second,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_y_first,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_y_second,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_z_first,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_z_second,
  input  wire logic signed [SAMPLE_WIDTH-1:0] rate_y_first,
  input  wire logic signed [SAMPLE_WIDTH-1:0] rate_y_second,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic signed [8:0]                   drive_value,
  output logic [7:0]                          drive_magnitude,
  output logic                                forward,
  output logic signed [31:0]                  tilt_angle
);

  cfg_t     cfg;
  cmd_t     cmd;
  status_t  status;
  reg_idx_t ridx;
  logic     wr;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{setpoint_angle: RST_SETPOINT, gain_p: RST_GAIN_P, gain_i: RST_GAIN_I,
               gain_d: RST_GAIN_D, filter_weight: RST_WEIGHT, time_step: RST_TSTEP,
               output_limit: RST_LIMIT};
    end else if (wr) begin
      unique case (ridx)
        REG_SETPOINT: cfg.setpoint_angle <= pwdata[23:0];
        REG_GAIN_P:   cfg.gain_p         <= pwdata[15:0];
        REG_GAIN_I:   cfg.gain_i         <= pwdata[15:0];
        REG_GAIN_D:   cfg.gain_d         <= pwdata[15:0];
        REG_WEIGHT:   cfg.filter_weight  <= pwdata[15:0];
        REG_TSTEP:    cfg.time_step      <= pwdata[23:0];
        REG_LIMIT:    cfg.output_limit   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_SETPOINT: prdata = {8'b0, cfg.setpoint_angle};
      REG_GAIN_P:   prdata = {16'b0, cfg.gain_p};
      REG_GAIN_I:   prdata = {16'b0, cfg.gain_i};
      REG_GAIN_D:   prdata = {16'b0, cfg.gain_d};
      REG_WEIGHT:   prdata = {16'b0, cfg.filter_weight};
      REG_TSTEP:    prdata = {8'b0, cfg.time_step};
      REG_LIMIT:    prdata = {24'b0, cfg.output_limit};
      default:      prdata = '0;
    endcase
  end

  tep_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  tep_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .status          (status),
    .accel_x_first   (accel_x_first),
    .accel_x_second  (accel_x_second),
    .accel_y_first   (accel_y_first),
    .accel_y_second  (accel_y_second),
    .accel_z_first   (accel_z_first),
    .accel_z_second  (accel_z_second),
    .rate_y_first    (rate_y_first),
    .rate_y_second   (rate_y_second),
    .drive_value     (drive_value),
    .drive_magnitude (drive_magnitude),
    .forward         (forward),
    .tilt_angle      (tilt_angle)
  );

endmodule

`default_nettype wire

>>> src/tep_checker.sv
// Port-level checks for the tilt / PID drive core, bound to the top level.
// Sees only top-level ports; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module tep_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              sample_valid,
  input wire logic              sample_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire logic signed [8:0] drive_value,
  input wire logic [7:0]        drive_magnitude,
  input wire logic              forward,
  input wire logic signed [31:0] tilt_angle
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(tilt_angle)
      && $stable(drive_value))
    else $error("stalled result beat changed");

  // one sample in flight: stall right after an accepted beat
  a_one: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("second sample taken while busy");

  a_mag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> drive_magnitude ==
      (drive_value[8] ? 8'(-drive_value) : drive_value[7:0]))
    else $error("drive magnitude mismatch");

  a_fwd: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> forward == (!drive_value[8] && drive_value != 9'sd0))
    else $error("forward flag mismatch");

endmodule

bind tilt_estimate_pid_drive_core tep_checker u_tep_checker (
  .clk             (clk),
  .rst             (rst),
  .sample_valid    (sample_valid),
  .sample_stall    (sample_stall),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .drive_value     (drive_value),
  .drive_magnitude (drive_magnitude),
  .forward         (forward),
  .tilt_angle      (tilt_angle)
);

`default_nettype wire

>>> tb/sv/tilt_estimate_pid_drive_core_tb.sv
// Self-checking bench for the tilt estimate / PID drive core.
// Needs tep_pkg and tilt_estimate_pid_drive_core; predicts untyped drive beats in-line.
`timescale 1ns / 1ps

module tilt_estimate_pid_drive_core_tb;
  import tep_pkg::*;

  localparam int RND_PER_PHASE = 205;
  localparam int N_PHASES      = 8;
  localparam int DRAIN_CYCLES  = 400;

  typedef struct {
    logic signed [8:0]  drive;
    logic [7:0]         mag;
    logic               fwd;
    logic signed [31:0] angle;
  } drive_beat_t;

  typedef struct {
    logic signed [15:0] f [8];
    bit                 typed;
    drive_beat_t        want;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [15:0] smp [8];
  logic result_valid;
  logic result_stall = 1'b1;
  logic signed [8:0] drive_value;
  logic [7:0] drive_magnitude;
  logic forward;
  logic signed [31:0] tilt_angle;

  initial for (int i = 0; i < 8; i++) smp[i] = '0;

  tilt_estimate_pid_drive_core DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .accel_x_first(smp[0]), .accel_x_second(smp[1]),
    .accel_y_first(smp[2]), .accel_y_second(smp[3]),
    .accel_z_first(smp[4]), .accel_z_second(smp[5]),
    .rate_y_first(smp[6]), .rate_y_second(smp[7]),
    .result_valid(result_valid), .result_stall(result_stall),
    .drive_value(drive_value), .drive_magnitude(drive_magnitude),
    .forward(forward), .tilt_angle(tilt_angle)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // predictor copy of registers and loop state
  logic [23:0] m_setpoint = RST_SETPOINT;
  logic [15:0] m_gp = RST_GAIN_P, m_gi = RST_GAIN_I, m_gd = RST_GAIN_D;
  logic [15:0] m_weight = RST_WEIGHT;
  logic [23:0] m_tstep = RST_TSTEP;
  logic [7:0]  m_limit = RST_LIMIT;
  longint m_angle = 0, m_prev_err = 0, m_err_sum = 0;

  drive_beat_t pending_drive [$];
  int mismatches = 0;
  int beats_in = 0, beats_out = 0;
  bit sender_no_gaps = 1'b0, recv_no_gaps = 1'b0;
  bit hold_req = 1'b0;

  function automatic longint clip_signed(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint pitch_q16(longint ax, longint ay, longint az);
    longint unsigned sq;
    longint x, y, z, nx;
    sq = longint'(ax * ax) + longint'(ay * ay);
    if (sq == 0 && az == 0) return 0;
    x = longint'(int_root(sq << 16));
    y = -az * 256;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_DEG[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_DEG[i];
      end
      x = nx;
    end
    return z;
  endfunction

  // advances the loop state by one sample and returns the drive beat
  function automatic drive_beat_t step_balance(logic signed [15:0] f [8]);
    longint ax, ay, az, gy, dt, w, lim, p, t, err, deriv, total, drv;
    drive_beat_t o;
    ax = (longint'(f[0]) + longint'(f[1])) / 2;
    ay = (longint'(f[2]) + longint'(f[3])) / 2;
    az = (longint'(f[4]) + longint'(f[5])) / 2;
    gy = (longint'(f[6]) + longint'(f[7])) / 2;
    dt = longint'({40'd0, m_tstep});
    w = longint'({48'd0, m_weight});
    lim = longint'({56'd0, m_limit});
    p = pitch_q16(ax, ay, az);
    t = m_angle + ((gy * dt) >>> 8);
    m_angle = clip_signed((w * t + (65536 - w) * p) >>> 16, 32);
    err = ((longint'($signed(m_setpoint)) - m_angle) * longint'(DEG_TO_RAD_Q32)) >>> 32;
    deriv = (dt == 0) ? 0 : clip_signed((err - m_prev_err) * 16777216 / dt, 32);
    m_err_sum = clip_signed(m_err_sum + ((err * dt) >>> 24), 40);
    m_prev_err = err;
    total = longint'({48'd0, m_gp}) * err + longint'({48'd0, m_gi}) * m_err_sum
          + longint'({48'd0, m_gd}) * deriv;
    drv = total / 16777216;
    if (drv > lim) drv = lim;
    if (drv < -lim) drv = -lim;
    o.drive = drv[8:0];
    o.mag = (drv < 0) ? 8'(-drv) : 8'(drv);
    o.fwd = drv > 0;
    o.angle = m_angle[31:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // typed-in expectation for the row being sent, if any
  bit next_typed = 1'b0;
  drive_beat_t next_want;

  always @(posedge clk) begin
    drive_beat_t e, p;
    if (!rst && result_valid && !result_stall) begin
      beats_out++;
      if (pending_drive.size() == 0) begin
        report_mismatch("unexpected drive beat, beats out vs in", beats_out, beats_in);
      end else begin
        e = pending_drive.pop_front();
        if (drive_value !== e.drive) report_mismatch("drive_value", drive_value, e.drive);
        if (drive_magnitude !== e.mag) report_mismatch("drive_magnitude", drive_magnitude, e.mag);
        if (forward !== e.fwd) report_mismatch("forward", forward, e.fwd);
        if (tilt_angle !== e.angle) report_mismatch("tilt_angle", tilt_angle, e.angle);
      end
    end
    if (!rst && sample_valid && !sample_stall) begin
      beats_in++;
      p = step_balance(smp);
      pending_drive.push_back(next_typed ? next_want : p);
    end
  end

  // result side: random stall per beat, plus one long hold on request
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (1500) @(negedge clk);
        hold_req = 1'b0;
      end
      n = recv_no_gaps ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
      @(negedge clk);
    end
  end

  task automatic send_sample(logic signed [15:0] f [8], bit typed, drive_beat_t want);
    int gap;
    gap = sender_no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    for (int i = 0; i < 8; i++) smp[i] <= f[i];
    next_typed <= typed;
    next_want <= want;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!(sample_valid && !sample_stall));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {r, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
    case (r)
      REG_SETPOINT: m_setpoint = v[23:0];
      REG_GAIN_P:   m_gp = v[15:0];
      REG_GAIN_I:   m_gi = v[15:0];
      REG_GAIN_D:   m_gd = v[15:0];
      REG_WEIGHT:   m_weight = v[15:0];
      REG_TSTEP:    m_tstep = v[23:0];
      REG_LIMIT:    m_limit = v[7:0];
      default: ;
    endcase
  endtask

  function automatic sample_row_t mk_row(int a0, int a1, int a2, int a3,
                                         int a4, int a5, int a6, int a7);
    sample_row_t r;
    r.f[0] = 16'(a0); r.f[1] = 16'(a1); r.f[2] = 16'(a2); r.f[3] = 16'(a3);
    r.f[4] = 16'(a4); r.f[5] = 16'(a5); r.f[6] = 16'(a6); r.f[7] = 16'(a7);
    r.typed = 1'b0;
    r.want = '{default: '0};
    return r;
  endfunction

  function automatic logic signed [15:0] near(int base, int spread);
    return 16'(base + $urandom_range(0, 2 * spread) - spread);
  endfunction

  initial begin
    sample_row_t dir [$];
    sample_row_t r;
    logic signed [15:0] f [8];
    drive_beat_t none;
    int sp;
    none = '{default: '0};

    // at rest after reset everything stays zero
    r = mk_row(0, 0, 0, 0, 0, 0, 0, 0);
    r.typed = 1'b1;
    dir.push_back(r);
    dir.push_back(mk_row(0, 0, 0, 0, -16384, -16384, 0, 0));  // no horizontal, pitch +90
    dir.push_back(mk_row(0, 0, 0, 0, 16384, 16384, 0, 0));    // pitch -90
    dir.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0));            // no acceleration
    dir.push_back(mk_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    dir.push_back(mk_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    dir.push_back(mk_row(32767, -32768, -32768, 32767, 32767, -32768, 32767, -32768));
    dir.push_back(mk_row(1, 0, -1, 0, 1, 0, -1, 0));          // halving truncates to zero
    dir.push_back(mk_row(3, 0, -3, 0, -3, 0, 3, 0));
    dir.push_back(mk_row(4000, 4100, 0, 0, -16000, -16200, 500, 520));
    dir.push_back(mk_row(-4000, -4100, 300, 280, -16000, -16200, -500, -520));
    dir.push_back(mk_row(16384, 16384, 0, 0, 0, 0, 0, 0));    // pitch zero, flat on x
    dir.push_back(mk_row(0, 0, -16384, -16384, 1, 1, 32767, 32767));
    dir.push_back(mk_row(0, 0, 0, 0, 0, 0, -32768, -32768));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir[i]) send_sample(dir[i].f, dir[i].typed, dir[i].want);
    wait_drained();

    // zero time step, ignored register write, tight clamp
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    write_reg(REG_TSTEP, 32'd0);
    write_reg(REG_GAIN_D, 32'd65535);
    write_reg(REG_LIMIT, 32'd0);
    foreach (dir[i]) send_sample(dir[i].f, 1'b0, none);
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          sp = 5898240;
          write_reg(REG_GAIN_P, 32'd65535); write_reg(REG_GAIN_I, 32'd65535);
          write_reg(REG_GAIN_D, 32'd65535); write_reg(REG_WEIGHT, 32'd65535);
          write_reg(REG_TSTEP, 32'hFF_FFFF); write_reg(REG_LIMIT, 32'd255);
        end
        1: begin
          sp = -5898240;
          write_reg(REG_GAIN_P, 32'd0); write_reg(REG_GAIN_I, 32'd0);
          write_reg(REG_GAIN_D, 32'd0); write_reg(REG_WEIGHT, 32'd0);
          write_reg(REG_TSTEP, 32'd0); write_reg(REG_LIMIT, 32'd0);
        end
        2: begin
          sp = 0;
          write_reg(REG_GAIN_P, 32'(RST_GAIN_P)); write_reg(REG_GAIN_I, 32'd256);
          write_reg(REG_GAIN_D, 32'd128); write_reg(REG_WEIGHT, 32'(RST_WEIGHT));
          write_reg(REG_TSTEP, 32'(RST_TSTEP)); write_reg(REG_LIMIT, 32'd255);
        end
        default: begin
          sp = int'($urandom_range(0, 11796480)) - 5898240;
          write_reg(REG_GAIN_P, $urandom_range(0, 65535));
          write_reg(REG_GAIN_I, $urandom_range(0, 65535));
          write_reg(REG_GAIN_D, $urandom_range(0, 65535));
          write_reg(REG_WEIGHT, $urandom_range(0, 65535));
          write_reg(REG_TSTEP, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24'hFF_FFFF));
          write_reg(REG_LIMIT, $urandom_range(0, 255));
        end
      endcase
      write_reg(REG_SETPOINT, sp);
      sender_no_gaps = (ph % 3 == 1);
      recv_no_gaps = (ph % 4 == 2);
      if (ph == 3) hold_req = 1'b1;
      for (int k = 0; k < RND_PER_PHASE; k++) begin
        if (k == 100 && ph == 4) begin
          // sender goes quiet until the pipeline is empty
          sample_valid <= 1'b0;
          while (pending_drive.size() != 0) @(negedge clk);
        end
        if ($urandom_range(0, 9) < 7) begin
          // mostly plausible, near-level readings from a pair of agreeing sensors
          f[0] = near(0, 3000); f[2] = near(0, 3000); f[4] = near(-16384, 3000);
          f[6] = near(0, 2500);
          f[1] = near(f[0], 200); f[3] = near(f[2], 200); f[5] = near(f[4], 200);
          f[7] = near(f[6], 200);
        end else begin
          for (int i = 0; i < 8; i++) f[i] = 16'($urandom);
        end
        send_sample(f, 1'b0, none);
      end
      wait_drained();
    end

    while (pending_drive.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d samples / %0d drive beats over %0d register settings,",
             beats_in, beats_out, N_PHASES + 2);
    $display("including zero time step, clamp extremes, a long output hold and idle gaps.");
    if (mismatches == 0 && pending_drive.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/tep_pkg.sv
src/tep_mul.sv
src/tep_ctrl.sv
src/tep_datapath.sv
src/tilt_estimate_pid_drive_core.sv
src/tep_checker.sv
tb/sv/tilt_estimate_pid_drive_core_tb.sv
